FILE: rtl/alarm_clock_set_controller_assert.svh
// Assertion macros for the alarm clock set controller.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ALARM_CLOCK_SET_CONTROLLER_ASSERT_SVH
`define ALARM_CLOCK_SET_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define ACSC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("acsc assertion failed");
`define ACSC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("acsc assertion failed");
`else
`define ACSC_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define ACSC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/acsc_pkg.sv
// Shared types, constants and the 7-segment table of the alarm clock set controller.
// No dependencies.
`default_nettype none
package acsc_pkg;
	localparam int IN_W   = 16;
	localparam int OUT_W  = 72;
	localparam int HIST_W = 13;

	localparam logic [10:0] LAST_MINUTE = 11'd1439;
	localparam logic [8:0]  TPB_RESET   = 9'd256;
	localparam logic [7:0]  BPM_RESET   = 8'd15;

	localparam logic [HIST_W-1:0] PRESS_PATTERN = 13'h1000;

	localparam logic [1:0] ENC_DETENT = 2'b11;
	localparam logic [1:0] ENC_UP     = 2'b01;
	localparam logic [1:0] ENC_DOWN   = 2'b10;

	localparam logic [7:0] COLON_DARK      = 8'hFF;
	localparam logic [7:0] COLON_ALARM_OFF = 8'hFC;
	localparam logic [7:0] COLON_ALARM_ON  = 8'hF8;

	localparam logic [10:0] HOUR_RECIP = 11'd1093;

	typedef enum logic [1:0] {
		REG_TICKS_PER_BLINK   = 2'd0,
		REG_BLINKS_PER_MINUTE = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [10:0] time_minutes;
		logic [10:0] alarm_minutes;
		logic [10:0] shown_minutes;
		logic        setting_time;
		logic        setting_alarm;
		logic        alarm_on;
		logic        blink_phase;
	} tick_result_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		unique case (digit)
			4'd0: code = 8'hC0;
			4'd1: code = 8'hF9;
			4'd2: code = 8'hA4;
			4'd3: code = 8'hB0;
			4'd4: code = 8'h99;
			4'd5: code = 8'h92;
			4'd6: code = 8'h82;
			4'd7: code = 8'hF8;
			4'd8: code = 8'h80;
			4'd9: code = 8'h98;
			default: code = 8'hFF;
		endcase
		return code;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/acsc_front.sv
// Front end: accepts ticks, debounces buttons, runs prescaler, modes and encoders.
// Depends on acsc_pkg and alarm_clock_set_controller_assert.svh.
`default_nettype none
`include "alarm_clock_set_controller_assert.svh"
module acsc_front #(
	parameter int BUTTON_COUNT = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output      logic                       s_axis_tready,
	input  wire logic [acsc_pkg::IN_W-1:0]  s_axis_tdata,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [8:0]                 cfg_data,
	input  wire logic                       q_full,
	output      logic                       push,
	output      acsc_pkg::tick_result_t     push_item
);
	import acsc_pkg::*;

	logic [8:0]        tpb_q;
	logic [7:0]        bpm_q;
	logic [8:0]        tick_q;
	logic [7:0]        blink_q;
	logic              blink_bit_q;
	logic              time_mode_q;
	logic              alarm_mode_q;
	logic              armed_q;
	logic [10:0]       clock_q;
	logic [10:0]       wake_q;
	logic [1:0]        enc0_prev_q;
	logic [1:0]        enc1_prev_q;
	logic              prime_q;
	logic [HIST_W-1:0] hist_q [BUTTON_COUNT];

	logic              accept;
	logic [7:0]        pins;
	logic [1:0]        cur0;
	logic [1:0]        cur1;
	logic [8:0]        tick_nx;
	logic              tick_zero;
	logic [8:0]        tick_d;
	logic [7:0]        blink_nx;
	logic              blink_zero;
	logic [7:0]        blink_d;
	logic              blink_bit_d;
	logic              minute_tick;
	logic [HIST_W-1:0] hist_d [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0] pressed;
	logic              time_mode_d;
	logic              alarm_mode_d;
	logic              armed_d;
	logic signed [7:0] delta;
	logic signed [11:0] clock_sum;
	logic signed [11:0] wake_sum;
	logic [10:0]       clock_d;
	logic [10:0]       wake_d;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !q_full;
	assign cfg_ready     = 1'b1;
	assign pins          = s_axis_tdata[7:0];
	assign cur0          = s_axis_tdata[9:8];
	assign cur1          = s_axis_tdata[11:10];

	always_comb begin
		tick_nx     = tick_q + 9'd1;
		tick_zero   = (tick_nx >= tpb_q) || (tick_nx == 9'd0);
		tick_d      = tick_zero ? 9'd0 : tick_nx;
		blink_nx    = blink_q + 8'd1;
		blink_zero  = (blink_nx >= bpm_q) || (blink_nx == 8'd0);
		blink_d     = blink_q;
		if (tick_zero) begin
			blink_d = blink_zero ? 8'd0 : blink_nx;
		end
		blink_bit_d = blink_bit_q ^ tick_zero;
		minute_tick = tick_zero && blink_zero && !time_mode_q;
	end

	always_comb begin
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			hist_d[b]  = {hist_q[b][HIST_W-2:0], pins[b]};
			pressed[b] = (hist_d[b] == PRESS_PATTERN);
		end
	end

	always_comb begin
		time_mode_d  = time_mode_q;
		alarm_mode_d = alarm_mode_q;
		armed_d      = armed_q;
		priority if (pressed == BUTTON_COUNT'(1)) begin
			time_mode_d = time_mode_q ^ !alarm_mode_q;
		end else if (pressed == BUTTON_COUNT'(2)) begin
			alarm_mode_d = alarm_mode_q ^ !time_mode_q;
		end else if (pressed == BUTTON_COUNT'(4)) begin
			armed_d = !armed_q;
		end
	end

	always_comb begin
		delta = 8'sd0;
		if (!prime_q) begin
			if (enc0_prev_q == ENC_DETENT && cur0 == ENC_UP) begin
				delta = delta + 8'sd1;
			end
			if (enc0_prev_q == ENC_DETENT && cur0 == ENC_DOWN) begin
				delta = delta - 8'sd1;
			end
			if (enc1_prev_q == ENC_DETENT && cur1 == ENC_UP) begin
				delta = delta + 8'sd60;
			end
			if (enc1_prev_q == ENC_DETENT && cur1 == ENC_DOWN) begin
				delta = delta - 8'sd60;
			end
		end
		clock_sum = $signed({1'b0, clock_q}) + $signed({11'd0, minute_tick});
		wake_sum  = $signed({1'b0, wake_q});
		if (time_mode_d) begin
			clock_sum = clock_sum + 12'(delta);
		end else if (alarm_mode_d) begin
			wake_sum = wake_sum + 12'(delta);
		end
		if (clock_sum < 12'sd0) begin
			clock_d = LAST_MINUTE;
		end else if (clock_sum > $signed({1'b0, LAST_MINUTE})) begin
			clock_d = 11'd0;
		end else begin
			clock_d = clock_sum[10:0];
		end
		if (wake_sum < 12'sd0) begin
			wake_d = LAST_MINUTE;
		end else if (wake_sum > $signed({1'b0, LAST_MINUTE})) begin
			wake_d = 11'd0;
		end else begin
			wake_d = wake_sum[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q <= TPB_RESET;
			bpm_q <= BPM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TICKS_PER_BLINK:   tpb_q <= cfg_data;
				REG_BLINKS_PER_MINUTE: bpm_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			blink_q      <= '0;
			blink_bit_q  <= 1'b0;
			time_mode_q  <= 1'b0;
			alarm_mode_q <= 1'b0;
			armed_q      <= 1'b0;
			clock_q      <= '0;
			wake_q       <= '0;
			enc0_prev_q  <= '0;
			enc1_prev_q  <= '0;
			prime_q      <= 1'b1;
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				hist_q[b] <= '0;
			end
		end else if (accept) begin
			tick_q       <= tick_d;
			blink_q      <= blink_d;
			blink_bit_q  <= blink_bit_d;
			time_mode_q  <= time_mode_d;
			alarm_mode_q <= alarm_mode_d;
			armed_q      <= armed_d;
			clock_q      <= clock_d;
			wake_q       <= wake_d;
			enc0_prev_q  <= cur0;
			enc1_prev_q  <= cur1;
			prime_q      <= 1'b0;
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				hist_q[b] <= hist_d[b];
			end
		end
	end

	assign push = accept;
	always_comb begin
		push_item.time_minutes  = clock_d;
		push_item.alarm_minutes = wake_d;
		push_item.shown_minutes = alarm_mode_d ? wake_d : clock_d;
		push_item.setting_time  = time_mode_d;
		push_item.setting_alarm = alarm_mode_d;
		push_item.alarm_on      = armed_d;
		push_item.blink_phase   = blink_bit_d;
	end

	`ACSC_ASSERT_IMPL(a_mode_lockout, clk, arst_n, 1'b1, !(time_mode_q && alarm_mode_q))
	`ACSC_ASSERT_IMPL(a_push_range, clk, arst_n, push,
		(push_item.time_minutes <= LAST_MINUTE) && (push_item.alarm_minutes <= LAST_MINUTE))
	`ACSC_ASSERT_NEXT(a_hold_idle, clk, arst_n, !accept,
		$stable(tick_q) && $stable(clock_q) && $stable(wake_q) && $stable(prime_q))
endmodule
`default_nettype wire

FILE: rtl/acsc_queue.sv
// Two-entry queue between the front and back ends of the alarm clock set controller.
// Depends on acsc_pkg.
`default_nettype none
module acsc_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire acsc_pkg::tick_result_t push_item,
	output      logic                   full,
	input  wire logic                   pop_ready,
	output      logic                   head_valid,
	output      acsc_pkg::tick_result_t head_item
);
	import acsc_pkg::*;

	tick_result_t mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         pop;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = mem_q[rd_ptr_q];
	assign pop        = pop_ready && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/acsc_back.sv
// Back end: splits the shown time into digits, encodes segments and the colon, holds output.
// Depends on acsc_pkg.
`default_nettype none
module acsc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       head_valid,
	input  wire acsc_pkg::tick_result_t     head_item,
	output      logic                       pop_ready,
	output      logic                       m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output      logic [acsc_pkg::OUT_W-1:0] m_axis_tdata
);
	import acsc_pkg::*;

	logic               adv;
	logic               valid_s1;
	tick_result_t       item_s1;
	logic [4:0]         hours_s1;
	logic [21:0]        hour_prod;
	logic [10:0]        hour_x60;
	logic [10:0]        min_full;
	logic [5:0]         mins;
	logic [3:0]         min_tens;
	logic [3:0]         min_ones;
	logic [3:0]         hour_tens;
	logic [3:0]         hour_ones;
	logic [7:0]         colon;
	logic [OUT_W-1:0]   data_d;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	assign adv       = !out_valid_q || m_axis_tready;
	assign pop_ready = adv;
	assign hour_prod = head_item.shown_minutes * HOUR_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= head_item;
			hours_s1 <= hour_prod[20:16];
		end
	end

	always_comb begin
		hour_x60 = {hours_s1, 6'd0} - {4'd0, hours_s1, 2'd0};
		min_full = item_s1.shown_minutes - hour_x60;
		mins     = min_full[5:0];
		priority if (mins >= 6'd50) begin
			min_tens = 4'd5;
		end else if (mins >= 6'd40) begin
			min_tens = 4'd4;
		end else if (mins >= 6'd30) begin
			min_tens = 4'd3;
		end else if (mins >= 6'd20) begin
			min_tens = 4'd2;
		end else if (mins >= 6'd10) begin
			min_tens = 4'd1;
		end else begin
			min_tens = 4'd0;
		end
		min_ones = 4'(mins - {min_tens[2:0], 3'd0} - {1'b0, min_tens[3:0], 1'b0});
		priority if (hours_s1 >= 5'd20) begin
			hour_tens = 4'd2;
		end else if (hours_s1 >= 5'd10) begin
			hour_tens = 4'd1;
		end else begin
			hour_tens = 4'd0;
		end
		hour_ones = 4'(hours_s1 - {hour_tens[1:0], 3'd0} - {2'd0, hour_tens[1:0], 1'b0});
		if (item_s1.blink_phase || item_s1.setting_time || item_s1.setting_alarm) begin
			colon = item_s1.alarm_on ? COLON_ALARM_ON : COLON_ALARM_OFF;
		end else begin
			colon = COLON_DARK;
		end
		data_d = {6'd0,
			item_s1.blink_phase, item_s1.alarm_on,
			item_s1.setting_alarm, item_s1.setting_time,
			colon,
			seg_code(hour_tens), seg_code(hour_ones),
			seg_code(min_tens), seg_code(min_ones),
			item_s1.alarm_minutes, item_s1.time_minutes};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= data_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
endmodule
`default_nettype wire

FILE: rtl/alarm_clock_set_controller.sv
// Alarm clock set controller: one timer tick in, one display result out.
// Result path: queue, then back-end input register, then output register.
// Throughput: one tick per cycle unless the queue is full.
// A two-entry queue decouples front and back so either side may stall alone.
// Reset (arst_n low, asynchronous): all counters, modes and times clear,
// registers return to 256 and 15, and the encoders prime on the first tick.
`default_nettype none
module alarm_clock_set_controller #(
	parameter int BUTTON_COUNT = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output      logic                       s_axis_tready,
	// [7:0] button_pins, [11:8] encoder_pins, [15:12] zero
	input  wire logic [acsc_pkg::IN_W-1:0]  s_axis_tdata,
	output      logic                       m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// [10:0] time_minutes, [21:11] alarm_minutes, [29:22] seg_minute_ones,
	// [37:30] seg_minute_tens, [45:38] seg_hour_ones, [53:46] seg_hour_tens,
	// [61:54] colon_code, [62] setting_time, [63] setting_alarm, [64] alarm_on,
	// [65] blink_phase, [71:66] zero
	output      logic [acsc_pkg::OUT_W-1:0] m_axis_tdata,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [8:0]                 cfg_data
);
	import acsc_pkg::*;

	logic         push;
	tick_result_t push_item;
	logic         q_full;
	logic         pop_ready;
	logic         head_valid;
	tick_result_t head_item;

	acsc_front #(
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	acsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop_ready  (pop_ready),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	acsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop_ready     (pop_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for alarm_clock_set_controller: drives ticks of button and encoder
// pins, predicts every display item in a local model and compares it field by field.
// Depends on acsc_pkg and the RTL of the block only.
module tb;
	import acsc_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam logic [79:0] SEG_CODES = {8'h98, 8'h80, 8'hF8, 8'h82, 8'h92,
		8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
	localparam logic [9:0] TURN_UP = {2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
	localparam logic [9:0] TURN_DOWN = {2'd3, 2'd1, 2'd0, 2'd2, 2'd3};

	typedef struct packed {
		logic [5:0]  pad;
		logic        blink_phase;
		logic        alarm_on;
		logic        setting_alarm;
		logic        setting_time;
		logic [7:0]  colon_code;
		logic [7:0]  seg_hour_tens;
		logic [7:0]  seg_hour_ones;
		logic [7:0]  seg_minute_tens;
		logic [7:0]  seg_minute_ones;
		logic [10:0] alarm_minutes;
		logic [10:0] time_minutes;
	} display_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [8:0]        cfg_data;

	logic [IN_W-1:0]   tick_queue[$];
	display_t          due_displays[$];
	int                ticks_taken;
	int                mismatches;
	int                quiet_cycles;
	int                send_idle;
	int                recv_idle;
	int                hold_left;
	bit                hold_done;
	bit                took_tick;
	logic [3:0]        enc_now;

	// local model state
	logic [15:0]       btn_hist[8];
	logic [8:0]        tick_cnt;
	logic [7:0]        blink_cnt;
	logic              blink_ph;
	logic              time_set;
	logic              alarm_set;
	logic              alarm_armed;
	logic              enc_prime;
	logic [1:0]        enc_last[2];
	int                clock_min;
	int                wake_min;
	logic [8:0]        tpb_reg;
	logic [7:0]        bpm_reg;

	alarm_clock_set_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int encoder_move(input int e, input logic [1:0] cur);
		int dir;
		dir = 0;
		if (cur != enc_last[e]) begin
			if (enc_last[e] == ENC_DETENT) begin
				if (cur == ENC_UP)
					dir = 1;
				else if (cur == ENC_DOWN)
					dir = -1;
			end
			enc_last[e] = cur;
		end
		return dir;
	endfunction

	task automatic predict_tick(input logic [IN_W-1:0] item);
		logic [7:0]  pins;
		logic [3:0]  enc;
		logic [7:0]  pressed;
		logic [15:0] h;
		int          nxt;
		int          delta;
		int          shown;
		display_t    d;
		pins = item[7:0];
		enc = item[11:8];
		nxt = (int'(tick_cnt) + 1) % 512;
		if (nxt >= tpb_reg)
			nxt = 0;
		tick_cnt = nxt;
		if (tick_cnt == 0) begin
			nxt = (int'(blink_cnt) + 1) % 256;
			if (nxt >= bpm_reg)
				nxt = 0;
			blink_cnt = nxt;
			blink_ph = !blink_ph;
			if (blink_cnt == 0 && !time_set)
				clock_min++;
		end
		pressed = '0;
		for (int b = 0; b < 8; b++) begin
			h = {btn_hist[b][14:0], pins[b]} | 16'hE000;
			btn_hist[b] = h;
			if (h == 16'hF000)
				pressed[b] = 1'b1;
		end
		case (pressed)
			8'h01: if (!alarm_set) time_set = !time_set;
			8'h02: if (!time_set) alarm_set = !alarm_set;
			8'h04: alarm_armed = !alarm_armed;
			default: ;
		endcase
		if (enc_prime) begin
			enc_last[0] = enc[1:0];
			enc_last[1] = enc[3:2];
			enc_prime = 1'b0;
		end else begin
			delta = encoder_move(0, enc[1:0]);
			delta = delta + 60 * encoder_move(1, enc[3:2]);
			if (time_set)
				clock_min += delta;
			else if (alarm_set)
				wake_min += delta;
		end
		if (clock_min < 0)
			clock_min = 1439;
		else if (clock_min > 1439)
			clock_min = 0;
		if (wake_min < 0)
			wake_min = 1439;
		else if (wake_min > 1439)
			wake_min = 0;
		shown = alarm_set ? wake_min : clock_min;
		d = '0;
		d.time_minutes = clock_min;
		d.alarm_minutes = wake_min;
		d.seg_minute_ones = SEG_CODES[(shown % 10) * 8 +: 8];
		d.seg_minute_tens = SEG_CODES[((shown % 60) / 10) * 8 +: 8];
		d.seg_hour_ones = SEG_CODES[((shown / 60) % 10) * 8 +: 8];
		d.seg_hour_tens = SEG_CODES[((shown / 600) % 10) * 8 +: 8];
		if (blink_ph || time_set || alarm_set)
			d.colon_code = alarm_armed ? COLON_ALARM_ON : COLON_ALARM_OFF;
		else
			d.colon_code = COLON_DARK;
		d.setting_time = time_set;
		d.setting_alarm = alarm_set;
		d.alarm_on = alarm_armed;
		d.blink_phase = blink_ph;
		due_displays.push_back(d);
	endtask

	task automatic field_check(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_display(input display_t got);
		display_t want;
		if (due_displays.size() == 0) begin
			mismatches++;
			$display("%0t: display item with none expected, actual %h", $time, got);
		end else begin
			want = due_displays.pop_front();
			field_check("time_minutes", want.time_minutes, got.time_minutes);
			field_check("alarm_minutes", want.alarm_minutes, got.alarm_minutes);
			field_check("seg_minute_ones", want.seg_minute_ones, got.seg_minute_ones);
			field_check("seg_minute_tens", want.seg_minute_tens, got.seg_minute_tens);
			field_check("seg_hour_ones", want.seg_hour_ones, got.seg_hour_ones);
			field_check("seg_hour_tens", want.seg_hour_tens, got.seg_hour_tens);
			field_check("colon_code", want.colon_code, got.colon_code);
			field_check("setting_time", want.setting_time, got.setting_time);
			field_check("setting_alarm", want.setting_alarm, got.setting_alarm);
			field_check("alarm_on", want.alarm_on, got.alarm_on);
			field_check("blink_phase", want.blink_phase, got.blink_phase);
			field_check("pad", want.pad, got.pad);
		end
	endtask

	// monitor: check results first, then predict the tick taken at this edge
	always @(posedge clk) begin
		took_tick = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_display(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) begin
				predict_tick(s_axis_tdata);
				void'(tick_queue.pop_front());
				ticks_taken++;
				took_tick = 1'b1;
			end
		end
	end

	// driver: hold an offered tick until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || took_tick) begin
			if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= tick_queue[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && ticks_taken >= 400) begin
			hold_done = 1'b1;
			hold_left = 200;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_tick(input logic [7:0] pins, input logic [3:0] enc);
		tick_queue.push_back({4'b0, enc, pins});
		enc_now = enc;
	endtask

	task automatic press_buttons(input logic [7:0] mask, input int lows);
		add_tick(8'hFF, enc_now);
		repeat (lows) add_tick(~mask, enc_now);
		add_tick(8'hFF, enc_now);
	endtask

	task automatic turn(input logic [1:0] which, input bit up0, input bit up1,
			input int clicks);
		logic [3:0] e;
		repeat (clicks) begin
			for (int k = 0; k < 5; k++) begin
				e = enc_now;
				if (which[0])
					e[1:0] = up0 ? TURN_UP[k*2 +: 2] : TURN_DOWN[k*2 +: 2];
				if (which[1])
					e[3:2] = up1 ? TURN_UP[k*2 +: 2] : TURN_DOWN[k*2 +: 2];
				add_tick(8'hFF, e);
			end
		end
	endtask

	task automatic random_ticks(input int count);
		int         start;
		int         sel;
		int         b;
		logic [7:0] mask;
		start = tick_queue.size();
		while (tick_queue.size() - start < count) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				b = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(2);
				press_buttons(8'd1 << b, 12 + $urandom_range(3));
			end else if (sel < 35) begin
				mask = (8'd1 << $urandom_range(2)) | (8'd1 << $urandom_range(7));
				press_buttons(mask, 12);
			end else if (sel < 70) begin
				turn($urandom_range(1, 3), $urandom_range(1), $urandom_range(1),
					$urandom_range(1, 8));
			end else if (sel < 80) begin
				press_buttons(8'd1 << $urandom_range(7), $urandom_range(1, 11));
			end else begin
				repeat ($urandom_range(1, 6))
					add_tick($urandom_range(255), $urandom_range(15));
			end
		end
	endtask

	task automatic drain();
		while (tick_queue.size() != 0 || due_displays.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [8:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_TICKS_PER_BLINK)
			tpb_reg = val;
		else
			bpm_reg = val[7:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [8:0] tpb, input logic [7:0] bpm, input int count);
		write_reg(REG_TICKS_PER_BLINK, tpb);
		write_reg(REG_BLINKS_PER_MINUTE, bpm);
		random_ticks(count);
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TICKS_PER_BLINK;
		cfg_data = '0;
		ticks_taken = 0;
		mismatches = 0;
		quiet_cycles = 0;
		hold_left = 0;
		hold_done = 1'b0;
		took_tick = 1'b0;
		enc_now = 4'hF;
		for (int b = 0; b < 8; b++)
			btn_hist[b] = '0;
		tick_cnt = '0;
		blink_cnt = '0;
		blink_ph = 1'b0;
		time_set = 1'b0;
		alarm_set = 1'b0;
		alarm_armed = 1'b0;
		enc_prime = 1'b1;
		enc_last[0] = '0;
		enc_last[1] = '0;
		clock_min = 0;
		wake_min = 0;
		tpb_reg = TPB_RESET;
		bpm_reg = BPM_RESET;
		send_idle = 29;
		recv_idle = 70;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// prime, idle step, all pins low, enter time-set, wrap both ways
		add_tick(8'hFF, 4'hF);
		add_tick(8'hFF, 4'h5);
		add_tick(8'h00, 4'h0);
		add_tick(8'hFF, 4'hF);
		repeat (12) add_tick(8'hFE, 4'hF);
		add_tick(8'hFF, 4'hA);
		add_tick(8'hFF, 4'hF);
		add_tick(8'hFF, 4'h5);
		add_tick(8'hFF, 4'hF);
		add_tick(8'hFF, 4'hD);
		random_ticks(150);
		drain();

		run_phase(9'd1, 8'd1, 200);
		run_phase(9'd256, 8'd255, 150);
		send_idle = 70;
		recv_idle = 29;
		run_phase(9'd3, 8'd2, 200);
		run_phase(9'd0, 8'd0, 150);
		run_phase(9'd511, 8'd7, 150);
		send_idle = 0;
		recv_idle = 0;
		run_phase(9'd2, 8'd4, 250);

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl
rtl/acsc_pkg.sv
rtl/acsc_front.sv
rtl/acsc_queue.sv
rtl/acsc_back.sv
rtl/alarm_clock_set_controller.sv
tb/sv/tb.sv
